@@ design/lzgd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzgd_pkg
// Shared widths and token constants for the group-flag LZ decompressor.
// ----------------------------------------------------------------------------
package lzgd_pkg;

  localparam int BYTE_W = 8;

  // token format
  localparam logic [7:0] FLAG_LITERAL   = 8'h80;
  localparam logic [3:0] DIST_HI_MASK   = 4'hF;
  localparam logic [8:0] SHORT_LEN_BIAS = 9'h002;
  localparam logic [8:0] LONG_LEN_BIAS  = 9'h012;
  localparam logic [8:0] MAX_COPY       = 9'h111;

  localparam int DIST_W = 13;   // 12-bit distance field plus one
  localparam int LEN_W  = 9;    // up to MAX_COPY

endpackage

@@ design/lz_group_flag_decompressor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_group_flag_decompressor_top
// Group-flag LZ payload decoder with a history ring and packed byte output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one compressed byte per
//   request, or a restart (op_i = 1) that clears the stream counters and
//   token state. The output channel (out_valid_o / out_stall_i) carries up
//   to BYTES_PER_RESULT decoded bytes per result, first byte in lane 0.
//   Write output_length through cfg_we_i / cfg_wdata_i while idle.
// Sequencing:
//   Flag bytes, leading reference bytes and restarts are taken in the idle state.
//   A literal goes through the put and emit states to the output register.
//   A copy visits a history read state then a put (write) state for each byte,
//   and an emit state for each packed result; the read-then-write order is
//   set by the single read port of the history ring.
//   in_stall_o is high for the whole of that work; the next request is
//   taken as soon as the last result is in the output register.
// Reset and stalls:
//   Reset clears all counters and token state; the history ring is not
//   cleared, and bytes before the start of the stream read as zero.
//   A stalled result holds in the output register and the sequencer waits
//   before loading the next one.
// ----------------------------------------------------------------------------
module lz_group_flag_decompressor_top
  import lzgd_pkg::*;
#(
  parameter int WINDOW_BYTES     = 4096,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  in_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_of_run_o,
  output logic        stream_done_o,
  output logic        bad_reference_o
);

  localparam int AW = $clog2(WINDOW_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PUT,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_REF2,
    PH_LEN
  } phase_e;

  state_e             state_q;
  phase_e             phase_q;
  logic [31:0]        out_len_q;
  logic [31:0]        produced_q;
  logic [AW-1:0]      wp_q;
  logic [7:0]         flag_bits_q;
  logic [3:0]         flags_left_q;
  logic [7:0]         first_ref_q;
  logic [7:0]         second_ref_q;
  logic               error_q;
  logic [DIST_W-1:0]  dist_q;
  logic [LEN_W-1:0]   rem_q;
  logic               lit_q;
  logic [7:0]         lit_byte_q;
  logic               src_ok_q;
  logic [63:0]        word_q;
  logic [3:0]         cnt_q;
  logic               out_valid_q;
  logic [63:0]        out_bytes_q;
  logic [3:0]         out_count_q;
  logic               out_last_q;
  logic               out_done_q;
  logic               out_bad_q;

  logic               accept;
  logic [31:0]        room;
  logic [LEN_W-1:0]   len_raw;
  logic [LEN_W-1:0]   len_clamped;
  logic [DIST_W-1:0]  dist_new;
  logic               dist_err;
  logic [3:0]         flags_left_dec;
  logic [AW:0]        wp_ext;
  logic [AW:0]        dist_ext;
  logic [AW:0]        src_ext;
  logic [AW-1:0]      wp_next;
  logic [7:0]         put_val;
  logic [7:0]         rd_data;
  logic               mem_we;
  logic               mem_re;
  logic               out_free;
  logic               emit_fire;
  logic [3:0]         cnt_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = (state_q == S_EMIT) && out_free;

  // length and distance of a reference completing on this byte
  always_comb begin
    if (phase_q == PH_LEN) begin
      len_raw  = LEN_W'(in_byte_i) + LONG_LEN_BIAS;
      dist_new = DIST_W'({first_ref_q[3:0] & DIST_HI_MASK, second_ref_q}) + DIST_W'(1);
    end else begin
      len_raw  = LEN_W'(first_ref_q[7:4]) + SHORT_LEN_BIAS;
      dist_new = DIST_W'({first_ref_q[3:0] & DIST_HI_MASK, in_byte_i}) + DIST_W'(1);
    end
  end

  assign room        = out_len_q - produced_q;
  assign len_clamped = (room < 32'(len_raw)) ? room[LEN_W-1:0] : len_raw;
  assign dist_err    = 32'(dist_new) > produced_q;
  assign flags_left_dec = (flags_left_q != 4'd0) ? flags_left_q - 4'd1 : 4'd0;

  // source address: write pointer minus distance, modulo the window
  assign wp_ext   = (AW + 1)'(wp_q);
  assign dist_ext = (AW + 1)'(dist_q);
  assign src_ext  = (wp_ext >= dist_ext) ? wp_ext - dist_ext
                                         : wp_ext + (AW + 1)'(WINDOW_BYTES) - dist_ext;
  assign wp_next  = (wp_q == AW'(WINDOW_BYTES - 1)) ? '0 : wp_q + AW'(1);

  assign put_val = lit_q ? lit_byte_q : (src_ok_q ? rd_data : 8'h00);
  assign mem_we  = (state_q == S_PUT);
  assign mem_re  = (state_q == S_READ);
  assign cnt_inc = cnt_q + 4'd1;

  lzgd_history #(
    .DEPTH (WINDOW_BYTES),
    .AW    (AW)
  ) u_history (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (wp_q),
    .wr_data_i (put_val),
    .rd_en_i   (mem_re),
    .rd_addr_i (src_ext[AW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_FLAG;
      out_len_q    <= '0;
      produced_q   <= '0;
      wp_q         <= '0;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      first_ref_q  <= '0;
      second_ref_q <= '0;
      error_q      <= 1'b0;
      dist_q       <= '0;
      rem_q        <= '0;
      lit_q        <= 1'b0;
      lit_byte_q   <= '0;
      src_ok_q     <= 1'b0;
      word_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_bytes_q  <= '0;
      out_count_q  <= '0;
      out_last_q   <= 1'b0;
      out_done_q   <= 1'b0;
      out_bad_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        out_len_q <= cfg_wdata_i;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (op_i) begin
              produced_q   <= '0;
              wp_q         <= '0;
              flag_bits_q  <= '0;
              flags_left_q <= '0;
              phase_q      <= PH_FLAG;
              first_ref_q  <= '0;
              second_ref_q <= '0;
              error_q      <= 1'b0;
            end else if (produced_q < out_len_q) begin
              unique case (phase_q)
                PH_FLAG: begin
                  flag_bits_q  <= in_byte_i;
                  flags_left_q <= 4'd8;
                  phase_q      <= PH_TOKEN;
                end
                PH_TOKEN: begin
                  if ((flag_bits_q & FLAG_LITERAL) != 8'h00) begin
                    lit_q        <= 1'b1;
                    lit_byte_q   <= in_byte_i;
                    rem_q        <= LEN_W'(1);
                    flag_bits_q  <= flag_bits_q << 1;
                    flags_left_q <= flags_left_dec;
                    phase_q      <= (flags_left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
                    state_q      <= S_PUT;
                  end else begin
                    first_ref_q <= in_byte_i;
                    phase_q     <= PH_REF2;
                  end
                end
                PH_REF2, PH_LEN: begin
                  if (phase_q == PH_REF2) begin
                    second_ref_q <= in_byte_i;
                  end
                  if (phase_q == PH_REF2 && first_ref_q[7:4] == 4'd0) begin
                    phase_q <= PH_LEN;
                  end else begin
                    lit_q        <= 1'b0;
                    dist_q       <= dist_new;
                    rem_q        <= len_clamped;
                    error_q      <= error_q | dist_err;
                    flag_bits_q  <= flag_bits_q << 1;
                    flags_left_q <= flags_left_dec;
                    phase_q      <= (flags_left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
                    state_q      <= S_READ;
                  end
                end
                default: ;
              endcase
            end
          end
        end

        S_READ: begin
          src_ok_q <= produced_q >= 32'(dist_q);
          state_q  <= S_PUT;
        end

        S_PUT: begin
          for (int i = 0; i < BYTES_PER_RESULT; i++) begin
            if (cnt_q == 4'(i)) begin
              word_q[8*i +: 8] <= put_val;
            end
          end
          cnt_q      <= cnt_inc;
          rem_q      <= rem_q - LEN_W'(1);
          produced_q <= produced_q + 32'd1;
          wp_q       <= wp_next;
          if (cnt_inc == 4'(BYTES_PER_RESULT) || rem_q == LEN_W'(1)) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_READ;
          end
        end

        S_EMIT: begin
          // wait for the output register to drain
          if (out_free) begin
            out_bytes_q <= word_q;
            out_count_q <= cnt_q;
            out_last_q  <= (rem_q == '0);
            out_done_q  <= (rem_q == '0) && (produced_q >= out_len_q);
            out_bad_q   <= error_q;
            word_q      <= '0;
            cnt_q       <= '0;
            state_q     <= (rem_q == '0) ? S_IDLE : S_READ;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_bytes_o     = out_bytes_q;
  assign byte_count_o    = out_count_q;
  assign last_of_run_o   = out_last_q;
  assign stream_done_o   = out_done_q;
  assign bad_reference_o = out_bad_q;

  // no history write goes past the configured length
  a_put_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |-> (produced_q < out_len_q))
    else $error("history write beyond output_length");

  // every result carries between one and BYTES_PER_RESULT bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_count_q != 4'd0 && out_count_q <= 4'(BYTES_PER_RESULT)))
    else $error("result byte count out of range");

  // stream completion is only reported on the final result of a run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("stream_done without last_of_run");

  // the packing buffer is empty whenever a new request may be taken
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q == 4'd0 && rem_q == '0))
    else $error("packing buffer not empty while idle");

endmodule

@@ design/lzgd_history.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzgd_history
// History ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzgd_history
  import lzgd_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [BYTE_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [BYTE_W-1:0] rd_data_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ verif/tb_lz_group_flag_decompressor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz_group_flag_decompressor_top
// Self-checking bench for the group-flag LZ payload decoder.
// Byte requests go in through a shared send task, and a bit-accurate decode
// predictor queues the packed words that each accepted request should give.
// A monitor compares every accepted output word with the oldest queued word.
// Directed tests cover literals, short and long copies, clamping at the end
// of the stream, references before the start and a zero length. Random
// streams follow, then a window wrap, an input back-pressure test and a tail
// with no idling. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_lz_group_flag_decompressor_top
  import lzgd_pkg::*;
;

  localparam int WINDOW          = 4096;
  localparam int LANES           = 8;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam logic OP_PAYLOAD = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [1:0] {
    PH_GROUP_FLAG,
    PH_TOKEN,
    PH_REF_LO,
    PH_LEN_BYTE
  } token_phase_e;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
    logic        done;
    logic        bad;
  } dec_word_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        op_i        = 1'b0;
  logic [7:0]  in_byte_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] out_bytes_o;
  logic [3:0]  byte_count_o;
  logic        last_of_run_o;
  logic        stream_done_o;
  logic        bad_reference_o;

  lz_group_flag_decompressor_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_bytes_o    (out_bytes_o),
    .byte_count_o   (byte_count_o),
    .last_of_run_o  (last_of_run_o),
    .stream_done_o  (stream_done_o),
    .bad_reference_o(bad_reference_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // decode predictor state
  logic [7:0]   hist_mem [WINDOW];
  logic [11:0]  wr_ptr;
  logic [31:0]  n_out;
  logic [31:0]  out_len_cfg = '0;
  logic [7:0]   flags;
  logic [3:0]   flags_rem;
  token_phase_e phase;
  logic [7:0]   ref_b1;
  logic [7:0]   ref_b2;
  logic         err_sticky;
  logic [7:0]   new_bytes[$];

  dec_word_t expected_words[$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  bit        hold_off_req   = 1'b0;
  bit        no_idle        = 1'b0;

  function automatic void reset_stream_state();
    wr_ptr     = '0;
    n_out      = '0;
    flags      = '0;
    flags_rem  = '0;
    phase      = PH_GROUP_FLAG;
    ref_b1     = '0;
    ref_b2     = '0;
    err_sticky = 1'b0;
  endfunction

  function automatic void store_decoded(input logic [7:0] v);
    hist_mem[wr_ptr] = v;
    wr_ptr = wr_ptr + 12'd1;
    n_out  = n_out + 32'd1;
    new_bytes.push_back(v);
  endfunction

  function automatic void copy_back(input int unsigned len);
    logic [31:0] distance;
    logic [31:0] room;
    logic [11:0] src;
    logic [7:0]  v;
    int unsigned n_copy;
    int unsigned i;
    distance = {20'd0, ref_b1[3:0] & DIST_HI_MASK, ref_b2} + 32'd1;
    room     = out_len_cfg - n_out;
    n_copy   = (len > room) ? room : len;
    if (distance > n_out) err_sticky = 1'b1;
    for (i = 0; i < n_copy; i++) begin
      // sources before the start of output read as zero
      v = 8'h00;
      if (n_out >= distance) begin
        src = wr_ptr - distance[11:0];
        v   = hist_mem[src];
      end
      store_decoded(v);
    end
  endfunction

  function automatic void advance_token();
    flags = flags << 1;
    if (flags_rem != 4'd0) flags_rem = flags_rem - 4'd1;
    phase = (flags_rem != 4'd0) ? PH_TOKEN : PH_GROUP_FLAG;
  endfunction

  function automatic void predict_decode(input logic op, input logic [7:0] b);
    dec_word_t w;
    int        pos;
    int        lane;
    new_bytes.delete();
    if (op == OP_RESTART) begin
      reset_stream_state();
      return;
    end
    if (n_out >= out_len_cfg) return;
    case (phase)
      PH_GROUP_FLAG: begin
        flags     = b;
        flags_rem = 4'd8;
        phase     = PH_TOKEN;
        return;
      end
      PH_TOKEN: begin
        if ((flags & FLAG_LITERAL) != 8'h00) begin
          store_decoded(b);
          advance_token();
        end else begin
          ref_b1 = b;
          phase  = PH_REF_LO;
          return;
        end
      end
      PH_REF_LO: begin
        ref_b2 = b;
        if (ref_b1[7:4] != 4'd0) begin
          copy_back(32'(ref_b1[7:4] + SHORT_LEN_BIAS));
          advance_token();
        end else begin
          phase = PH_LEN_BYTE;
          return;
        end
      end
      default: begin
        copy_back(32'(b + LONG_LEN_BIAS));
        advance_token();
      end
    endcase
    // pack into words, first byte in the lowest lane
    pos = 0;
    while (pos < new_bytes.size()) begin
      w    = '0;
      lane = 0;
      while (lane < LANES && pos < new_bytes.size()) begin
        w.data = w.data | (64'(new_bytes[pos]) << (8 * lane));
        lane++;
        pos++;
      end
      w.cnt  = lane[3:0];
      w.last = (pos >= new_bytes.size());
      w.done = w.last && (n_out >= out_len_cfg);
      w.bad  = err_sticky;
      expected_words.push_back(w);
    end
  endfunction

  function automatic void check_result();
    dec_word_t want;
    if (expected_words.size() == 0) begin
      $error("result with no request pending: out_bytes %h byte_count %0d",
             out_bytes_o, byte_count_o);
      mismatch_count++;
      return;
    end
    want = expected_words.pop_front();
    if (out_bytes_o !== want.data) begin
      $error("out_bytes expected %h actual %h", want.data, out_bytes_o);
      mismatch_count++;
    end
    if (byte_count_o !== want.cnt) begin
      $error("byte_count expected %0d actual %0d", want.cnt, byte_count_o);
      mismatch_count++;
    end
    if (last_of_run_o !== want.last) begin
      $error("last_of_run expected %b actual %b", want.last, last_of_run_o);
      mismatch_count++;
    end
    if (stream_done_o !== want.done) begin
      $error("stream_done expected %b actual %b", want.done, stream_done_o);
      mismatch_count++;
    end
    if (bad_reference_o !== want.bad) begin
      $error("bad_reference expected %b actual %b", want.bad, bad_reference_o);
      mismatch_count++;
    end
  endfunction

  // check output before predicting, so a word never meets its own request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_o) predict_decode(op_i, in_byte_i);
      if (cfg_we_i) out_len_cfg = cfg_wdata_i;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, free-running stretches, one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i  <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  task automatic send_req(input logic op, input logic [7:0] b);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    // let a trailing flag or reference byte finish inside the block
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic start_stream(input logic [31:0] len);
    wait_for_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_req(OP_RESTART, 8'($urandom));
  endtask

  // well-formed groups with random content; noise is a stray byte or a restart
  task automatic random_tokens(input logic [31:0] len, input int max_items,
                               input int noise_pct, input bit wide);
    longint unsigned made;
    int              sent;
    int              k;
    int unsigned     distance;
    int unsigned     ext;
    logic [11:0]     d;
    logic [3:0]      nib;
    logic [7:0]      flag;
    made = 0;
    sent = 0;
    while (sent < max_items && made < len) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        if ($urandom_range(0, 3) == 0) begin
          send_req(OP_RESTART, 8'($urandom));
          made = 0;
        end else begin
          send_req(OP_PAYLOAD, 8'($urandom));
        end
        sent++;
      end else begin
        flag = 8'($urandom);
        if (wide) flag = (made == 0) ? 8'h80 : 8'h00;
        send_req(OP_PAYLOAD, flag);
        sent++;
        for (k = 7; k >= 0 && made < len; k--) begin
          if (flag[k]) begin
            send_req(OP_PAYLOAD, 8'($urandom));
            made++;
            sent++;
          end else begin
            if (made == 0 || (!wide && $urandom_range(0, 9) == 0)) begin
              distance = $urandom_range(1, WINDOW);
            end else begin
              distance = $urandom_range(1, (made > WINDOW) ? WINDOW : made);
            end
            if (wide && made >= WINDOW && $urandom_range(0, 3) == 0) distance = WINDOW;
            d = 12'(distance - 1);
            if (wide || $urandom_range(0, 3) == 0) begin
              if (wide) begin
                ext = $urandom_range(200, 255);
              end else if ($urandom_range(0, 7) == 0) begin
                ext = $urandom_range(0, 255);
              end else begin
                ext = $urandom_range(0, 20);
              end
              send_req(OP_PAYLOAD, {4'h0, d[11:8]});
              send_req(OP_PAYLOAD, d[7:0]);
              send_req(OP_PAYLOAD, 8'(ext));
              made += ext + LONG_LEN_BIAS;
              sent += 3;
            end else begin
              nib = 4'($urandom_range(1, 15));
              send_req(OP_PAYLOAD, {nib, d[11:8]});
              send_req(OP_PAYLOAD, d[7:0]);
              made += nib + SHORT_LEN_BIAS;
              sent += 2;
            end
          end
        end
      end
    end
  endtask

  task automatic run_stream(input logic [31:0] len, input int max_items,
                            input int noise_pct, input bit wide);
    start_stream(len);
    random_tokens(len, max_items, noise_pct, wide);
  endtask

  task automatic test_literal_group();
    start_stream(32'hFFFF_FFFF);
    send_req(OP_PAYLOAD, 8'hFF);
    send_req(OP_PAYLOAD, 8'h00);
    send_req(OP_PAYLOAD, 8'hFF);
    send_req(OP_PAYLOAD, 8'h01);
    send_req(OP_PAYLOAD, 8'h80);
  endtask

  task automatic test_short_and_long_copies();
    start_stream(32'd64);
    send_req(OP_PAYLOAD, 8'hC0);
    send_req(OP_PAYLOAD, 8'h41);
    send_req(OP_PAYLOAD, 8'h42);
    // distance 2, longest short length
    send_req(OP_PAYLOAD, 8'hF0);
    send_req(OP_PAYLOAD, 8'h01);
    // distance 1, longest copy, clamped at the end of the stream
    send_req(OP_PAYLOAD, 8'h00);
    send_req(OP_PAYLOAD, 8'h00);
    send_req(OP_PAYLOAD, 8'hFF);
    // stream finished: drop
    send_req(OP_PAYLOAD, 8'h5A);
  endtask

  task automatic test_reference_before_start();
    start_stream(32'd40);
    send_req(OP_PAYLOAD, 8'h00);
    send_req(OP_PAYLOAD, 8'h3F);
    send_req(OP_PAYLOAD, 8'hFF);
    send_req(OP_PAYLOAD, 8'h10);
    send_req(OP_PAYLOAD, 8'h00);
  endtask

  task automatic test_zero_length();
    start_stream(32'd0);
    send_req(OP_PAYLOAD, 8'hFF);
    send_req(OP_PAYLOAD, 8'h00);
  endtask

  task automatic test_random_streams();
    run_stream(32'd1, 4, 0, 1'b0);
    run_stream($urandom_range(20, 300), 8, 10, 1'b0);
    run_stream($urandom | 32'h8000_0000, 8, 10, 1'b0);
  endtask

  task automatic test_window_wrap();
    run_stream(32'd4400, 80, 0, 1'b1);
  endtask

  task automatic test_input_backpressure();
    start_stream(32'd300);
    hold_off_req = 1'b1;
    random_tokens(32'd300, 8, 0, 1'b0);
  endtask

  task automatic test_no_idle_tail();
    wait_for_idle();
    no_idle = 1'b1;
    run_stream($urandom_range(40, 120), 8, 5, 1'b0);
  endtask

  initial begin
    reset_stream_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_literal_group();
    test_short_and_long_copies();
    test_reference_before_start();
    test_zero_length();
    test_random_streams();
    test_window_wrap();
    test_input_backpressure();
    test_no_idle_tail();
    wait_for_idle();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
